@@ hw/rtl/rtt_pkg.sv @@
// shared types and constants of the retransmission timeout estimator
`default_nettype none

package rtt_pkg;

    // field widths
    localparam int RttW  = 16;
    localparam int EstW  = 19;
    localparam int CntW  = 8;
    localparam int MultW = 4;
    localparam int TsW   = 32;

    // event selector codes
    localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
    localparam logic [1:0] FUNC_REINIT  = 2'd2;

    // register indexes (byte address 4*index)
    localparam logic [1:0] REG_MIN_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_MAX_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_RETRY_LIMIT = 2'd2;
    localparam logic [1:0] REG_DEV_MULT    = 2'd3;

    // reset values
    localparam logic [RttW-1:0]  MIN_TIMEOUT_RST = 16'd2000;
    localparam logic [RttW-1:0]  MAX_TIMEOUT_RST = 16'd60000;
    localparam logic [CntW-1:0]  RETRY_LIMIT_RST = 8'd12;
    localparam logic [MultW-1:0] DEV_MULT_RST    = 4'd3;
    localparam logic [EstW-1:0]  DEV_INIT_X4     = 19'd4000;
    localparam logic [EstW-1:0]  EST_MAX         = 19'h7FFFF;
    localparam logic [RttW-1:0]  TIMEOUT_RST     = 16'd3000;
    localparam logic [RttW-1:0]  RTT_SAT         = 16'hFFFF;

    typedef struct packed {
        logic [RttW-1:0]  min_timeout;
        logic [RttW-1:0]  max_timeout;
        logic [CntW-1:0]  retry_limit;
        logic [MultW-1:0] dev_mult;
    } t_cfg;

    typedef struct packed {
        logic [RttW-1:0] timeout_ms;
        logic            give_up;
        logic [RttW-1:0] measured_rtt_ms;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/rtt_cfg_regs.sv @@
// configuration register bank with its bus port
`default_nettype none

module rtt_cfg_regs (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_psel,
    input  wire logic                 i_penable,
    input  wire logic                 i_pwrite,
    input  wire logic [3:0]           i_paddr,
    input  wire logic [31:0]          i_pwdata,
    output logic      [31:0]          o_prdata,
    output logic                      o_pready,
    output rtt_pkg::t_cfg             o_cfg
);
    import rtt_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign reg_idx  = i_paddr[3:2];
    assign wr_en    = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_timeout <= MIN_TIMEOUT_RST;
            r_cfg.max_timeout <= MAX_TIMEOUT_RST;
            r_cfg.retry_limit <= RETRY_LIMIT_RST;
            r_cfg.dev_mult    <= DEV_MULT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MIN_TIMEOUT: r_cfg.min_timeout <= i_pwdata[RttW-1:0];
                REG_MAX_TIMEOUT: r_cfg.max_timeout <= i_pwdata[RttW-1:0];
                REG_RETRY_LIMIT: r_cfg.retry_limit <= i_pwdata[CntW-1:0];
                REG_DEV_MULT:    r_cfg.dev_mult    <= i_pwdata[MultW-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            REG_MIN_TIMEOUT: o_prdata = {16'd0, r_cfg.min_timeout};
            REG_MAX_TIMEOUT: o_prdata = {16'd0, r_cfg.max_timeout};
            REG_RETRY_LIMIT: o_prdata = {24'd0, r_cfg.retry_limit};
            REG_DEV_MULT:    o_prdata = {28'd0, r_cfg.dev_mult};
            default:         o_prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/rtt_est_core.sv @@
// estimator state and the single-pass update of srtt, deviation and timeout
`default_nettype none

module rtt_est_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_update,
    input  wire logic [1:0]           i_func,
    input  wire logic [15:0]          i_rtt,
    input  wire logic [7:0]           i_retransmit_count,
    input  wire rtt_pkg::t_cfg        i_cfg,
    output rtt_pkg::t_result          o_result
);
    import rtt_pkg::*;

    logic [EstW-1:0] r_srtt_x8, n_srtt_x8;
    logic [EstW-1:0] r_dev_x4,  n_dev_x4;
    logic [RttW-1:0] r_timeout, n_timeout;

    logic [RttW-1:0]   est_ms;
    logic [EstW:0]     s_sum;
    logic [EstW-1:0]   s_new;
    logic [RttW-1:0]   abs_err;
    logic [EstW:0]     d_sum;
    logic [EstW-1:0]   d_new;
    logic [EstW+3:0]   prod;
    logic [EstW+4:0]   tmo_sum;
    logic [RttW-1:0]   tmo_calc;
    logic [RttW-1:0]   tmo_double;

    // clamp with min checked first, so crossed limits favor min
    function automatic logic [RttW-1:0] clamp_to(input logic [EstW+4:0] v, input t_cfg cfg);
        logic [RttW-1:0] res;
        if (v < {8'd0, cfg.min_timeout}) begin
            res = cfg.min_timeout;
        end else if (v > {8'd0, cfg.max_timeout}) begin
            res = cfg.max_timeout;
        end else begin
            res = v[RttW-1:0];
        end
        return res;
    endfunction

    // smoothed rtt: srtt_x8 += rtt - srtt, saturated
    assign est_ms = r_srtt_x8[EstW-1:3];
    assign s_sum  = {1'b0, r_srtt_x8} - {4'd0, est_ms} + {4'd0, i_rtt};
    assign s_new  = s_sum[EstW] ? EST_MAX : s_sum[EstW-1:0];

    // mean deviation: dev_x4 += |err| - dev, saturated
    assign abs_err = (i_rtt >= est_ms) ? (i_rtt - est_ms) : (est_ms - i_rtt);
    assign d_sum   = {1'b0, r_dev_x4} - {3'd0, r_dev_x4[EstW-1:2]} + {4'd0, abs_err};
    assign d_new   = d_sum[EstW] ? EST_MAX : d_sum[EstW-1:0];

    // next estimator values
    always_comb begin
        case (i_func)
            FUNC_SAMPLE: begin
                n_srtt_x8 = s_new;
                n_dev_x4  = d_new;
            end
            FUNC_REINIT: begin
                n_srtt_x8 = '0;
                n_dev_x4  = DEV_INIT_X4;
            end
            default: begin
                n_srtt_x8 = r_srtt_x8;
                n_dev_x4  = r_dev_x4;
            end
        endcase
    end

    // timeout from the new estimators, and the doubled backoff
    assign prod       = {{EstW{1'b0}}, i_cfg.dev_mult} * {6'd0, n_dev_x4[EstW-1:2]};
    assign tmo_sum    = {8'd0, n_srtt_x8[EstW-1:3]} + {1'b0, prod};
    assign tmo_calc   = clamp_to(tmo_sum, i_cfg);
    assign tmo_double = clamp_to({7'd0, r_timeout, 1'b0}, i_cfg);

    always_comb begin
        case (i_func)
            FUNC_SAMPLE:  n_timeout = tmo_calc;
            FUNC_REINIT:  n_timeout = tmo_calc;
            FUNC_TIMEOUT: n_timeout = tmo_double;
            default:      n_timeout = r_timeout;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srtt_x8 <= '0;
            r_dev_x4  <= DEV_INIT_X4;
            r_timeout <= TIMEOUT_RST;
        end else if (i_update) begin
            r_srtt_x8 <= n_srtt_x8;
            r_dev_x4  <= n_dev_x4;
            r_timeout <= n_timeout;
        end
    end

    // result word
    assign o_result.timeout_ms      = n_timeout;
    assign o_result.give_up         = (i_func == FUNC_TIMEOUT) &&
                                      (i_retransmit_count > i_cfg.retry_limit);
    assign o_result.measured_rtt_ms = (i_func == FUNC_SAMPLE) ? i_rtt : '0;

endmodule

`default_nettype wire

@@ hw/rtl/rtt_retransmit_timeout_estimator.sv @@
// top level of the retransmission timeout estimator
// One event word in, one result word out. An event is captured in an input
// register (the round trip now_ms - sent_ms is taken modulo 2^32 and
// saturated to 65535 ms on the way in), then the smoothed RTT, the mean
// deviation and the timeout are updated in one pass into a result register.
// The block takes one word every cycle, through the input register and then
// the result register; the only limit is the output side taking results. Config writes
// take effect at the next event and are meant to be made while idle.
`default_nettype none

module rtt_retransmit_timeout_estimator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // event stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // now_ms[31:0], sent_ms[63:32], retransmit_count[71:64]
    input  wire logic [1:0]  s_axis_tuser,   // func[1:0]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // timeout_ms[15:0], give_up[16], measured_rtt_ms[32:17], zero[39:33]
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import rtt_pkg::*;

    t_cfg      cfg;
    t_result   result;

    logic                r_in_valid;
    logic [1:0]          r_in_func;
    logic [RttW-1:0]     r_in_rtt;
    logic [CntW-1:0]     r_in_count;
    logic                r_out_valid;
    t_result             r_out;

    logic [TsW-1:0]      diff;
    logic [RttW-1:0]     rtt_sat;
    logic                in_load;
    logic                out_free;
    logic                move;

    // handshake
    assign out_free      = !r_out_valid || m_axis_tready;
    assign move          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    // measured round trip, wrapped then saturated
    assign diff    = s_axis_tdata[31:0] - s_axis_tdata[63:32];
    assign rtt_sat = (|diff[TsW-1:RttW]) ? RTT_SAT : diff[RttW-1:0];

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_func  <= s_axis_tuser;
            r_in_rtt   <= rtt_sat;
            r_in_count <= s_axis_tdata[71:64];
        end
    end

    rtt_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    rtt_est_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_update           (move),
        .i_func             (r_in_func),
        .i_rtt              (r_in_rtt),
        .i_retransmit_count (r_in_count),
        .i_cfg              (cfg),
        .o_result           (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.measured_rtt_ms, r_out.give_up, r_out.timeout_ms};

endmodule

`default_nettype wire
